// ----- src/t1bd_pkg.sv -----
// ----------------------------------------------------------------------------
// t1bd_pkg
// Shared types, codes and check-byte arithmetic for the T=1 block deframer.
// ----------------------------------------------------------------------------
package t1bd_pkg;

	// register indexes on the configuration port
	localparam int unsigned RegCount   = 3;
	localparam int unsigned AddrWidth  = 4;
	localparam logic [1:0]  RegNad     = 2'd0;
	localparam logic [1:0]  RegCrcMode = 2'd1;
	localparam logic [1:0]  RegIgnore  = 2'd2;

	// check constants
	localparam logic [15:0] CrcInit = 16'hffff;
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [7:0]  LenBad  = 8'hff;

	// result kinds
	localparam logic KindInfo   = 1'b0;
	localparam logic KindStatus = 1'b1;

	// status codes
	localparam logic [1:0] StOk  = 2'd0;
	localparam logic [1:0] StNad = 2'd1;
	localparam logic [1:0] StLen = 2'd2;
	localparam logic [1:0] StEdc = 2'd3;

	// receive phases, one-hot
	typedef enum logic [6:0] {
		PH_NAD  = 7'b0000001,
		PH_PCB  = 7'b0000010,
		PH_LEN  = 7'b0000100,
		PH_INF  = 7'b0001000,
		PH_EDC0 = 7'b0010000,
		PH_EDC1 = 7'b0100000,
		PH_SKIP = 7'b1000000
	} phase_t;

	// live configuration
	typedef struct packed {
		logic [7:0] expected_nad;
		logic       crc_mode;
		logic       ignore_edc_error;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic       kind;
		logic [7:0] info_byte;
		logic [7:0] control_byte;
		logic [7:0] info_length;
		logic [1:0] status;
	} result_t;

	// one received item
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} rx_item_t;

	// crc over one byte, msb first, eight unrolled steps
	function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] crc;
		logic [15:0] dat;
		crc = acc;
		dat = {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (crc[15] ^ dat[15]) begin
				crc = crc ^ CrcPoly;
			end
			crc = {crc[14:0], 1'b0};
			dat = {dat[14:0], 1'b0};
		end
		return crc;
	endfunction

	// running check: lrc keeps the low byte only
	function automatic logic [15:0] check_update(input logic mode, input logic [15:0] acc,
			input logic [7:0] b);
		if (mode) begin
			return crc_byte(acc, b);
		end
		return {8'h00, acc[7:0] ^ b};
	endfunction

endpackage

// ----- src/t1bd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// t1bd_cfg_regs
// APB-style register file holding the address and check settings.
// ----------------------------------------------------------------------------
module t1bd_cfg_regs
	import t1bd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	logic [7:0] nad_q;
	logic       crc_mode_q;
	logic       ignore_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[AddrWidth-1:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nad_q      <= '0;
			crc_mode_q <= 1'b0;
			ignore_q   <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				RegNad:     nad_q      <= pwdata[7:0];
				RegCrcMode: crc_mode_q <= pwdata[0];
				RegIgnore:  ignore_q   <= pwdata[0];
				default:    ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			RegNad:     prdata = {24'h0, nad_q};
			RegCrcMode: prdata = {31'h0, crc_mode_q};
			RegIgnore:  prdata = {31'h0, ignore_q};
			default:    prdata = '0;
		endcase
	end

	assign cfg.expected_nad     = nad_q;
	assign cfg.crc_mode         = crc_mode_q;
	assign cfg.ignore_edc_error = ignore_q;

endmodule

// ----- src/t1bd_in_stage.sv -----
// ----------------------------------------------------------------------------
// t1bd_in_stage
// Input register: holds one received item until the parser takes it.
// ----------------------------------------------------------------------------
module t1bd_in_stage
	import t1bd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rx_item_t in_item,
	input  logic     advance,
	output logic     valid_s1,
	output rx_item_t item_s1
);

	// free when empty or when the held item moves on this cycle
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ----- src/t1bd_parser.sv -----
// ----------------------------------------------------------------------------
// t1bd_parser
// Block phase tracking, field capture, check-byte accumulation and result
// selection for one byte per cycle while advance is high.
// ----------------------------------------------------------------------------
module t1bd_parser
	import t1bd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     advance,
	input  rx_item_t item_s1,
	output logic     emit,
	output result_t  result
);

	phase_t      phase_q, phase_n;
	logic [15:0] acc_q, acc_n;
	logic [7:0]  ctl_q, ctl_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  left_q, left_n;
	logic [7:0]  b;
	logic        last;
	logic [7:0]  left_dec;
	logic        bad_lo;
	logic        bad_hi;

	assign b        = item_s1.rx_byte;
	assign last     = item_s1.frame_end;
	assign left_dec = left_q - 8'd1;
	assign bad_lo   = (b != acc_q[7:0]) && !cfg.ignore_edc_error;
	assign bad_hi   = (left_q != 8'd0) || ((b != acc_q[15:8]) && !cfg.ignore_edc_error);

	// next state and result for the held byte
	always_comb begin
		phase_n = phase_q;
		acc_n   = acc_q;
		ctl_n   = ctl_q;
		len_n   = len_q;
		left_n  = left_q;
		emit    = 1'b0;
		result.kind      = KindStatus;
		result.info_byte = 8'h00;
		result.status    = StOk;
		case (phase_q)
			PH_NAD: begin
				ctl_n  = 8'h00;
				len_n  = 8'h00;
				left_n = 8'h00;
				if (b != cfg.expected_nad) begin
					emit          = 1'b1;
					result.status = StNad;
					phase_n       = last ? PH_NAD : PH_SKIP;
				end else begin
					acc_n = check_update(cfg.crc_mode, cfg.crc_mode ? CrcInit : 16'h0000, b);
					if (last) begin
						emit          = 1'b1;
						result.status = StLen;
						phase_n       = PH_NAD;
					end else begin
						phase_n = PH_PCB;
					end
				end
			end
			PH_PCB: begin
				ctl_n = b;
				acc_n = check_update(cfg.crc_mode, acc_q, b);
				if (last) begin
					emit          = 1'b1;
					result.status = StLen;
					phase_n       = PH_NAD;
				end else begin
					phase_n = PH_LEN;
				end
			end
			PH_LEN: begin
				len_n = b;
				if (b == LenBad || last) begin
					emit          = 1'b1;
					result.status = StLen;
					phase_n       = last ? PH_NAD : PH_SKIP;
				end else begin
					acc_n   = check_update(cfg.crc_mode, acc_q, b);
					left_n  = b;
					phase_n = (b == 8'h00) ? PH_EDC0 : PH_INF;
				end
			end
			PH_INF: begin
				emit = 1'b1;
				if (last) begin
					result.status = StLen;
					phase_n       = PH_NAD;
				end else begin
					acc_n            = check_update(cfg.crc_mode, acc_q, b);
					left_n           = left_dec;
					result.kind      = KindInfo;
					result.info_byte = b;
					if (left_dec == 8'h00) begin
						phase_n = PH_EDC0;
					end
				end
			end
			PH_EDC0: begin
				if (!cfg.crc_mode) begin
					emit          = 1'b1;
					result.status = bad_lo ? StEdc : StOk;
					phase_n       = last ? PH_NAD : PH_SKIP;
				end else if (last) begin
					emit          = 1'b1;
					result.status = StLen;
					phase_n       = PH_NAD;
				end else begin
					left_n  = {7'h00, bad_lo};
					phase_n = PH_EDC1;
				end
			end
			PH_EDC1: begin
				left_n        = 8'h00;
				emit          = 1'b1;
				result.status = bad_hi ? StEdc : StOk;
				phase_n       = last ? PH_NAD : PH_SKIP;
			end
			default: begin
				// skip to end of frame
				if (last) begin
					phase_n = PH_NAD;
				end
			end
		endcase
		result.control_byte = ctl_n;
		result.info_length  = len_n;
	end

	// block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NAD;
			acc_q   <= '0;
			ctl_q   <= '0;
			len_q   <= '0;
			left_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			ctl_q   <= ctl_n;
			len_q   <= len_n;
			left_q  <= left_n;
		end
	end

endmodule

// ----- src/t1bd_out_stage.sv -----
// ----------------------------------------------------------------------------
// t1bd_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module t1bd_out_stage
	import t1bd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	output logic    free,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t result_q
);

	// slot can take a new item when empty or being emptied
	assign free = !out_valid || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && free) begin
			result_q <= result;
		end
	end

endmodule

// ----- src/t1_block_deframer.sv -----
// ----------------------------------------------------------------------------
// t1_block_deframer
// Receive-side parser for smart-card T=1 blocks.
// ----------------------------------------------------------------------------
// Usage: feed the received bytes of a block on the input channel (rx_byte,
// with frame_end on the last byte the link delivered). Information bytes
// come out one per item with kind 0; each block ends with exactly one
// status item (kind 1) carrying the captured PCB and LEN and a status code.
// Bytes after the status up to frame_end produce nothing.
// The accepting edge loads the input register; the byte's result is loaded
// into the result register when the byte moves on, which waits while the
// result register holds an item the receiver has not taken. Throughput: one
// byte per cycle while the receiver takes results; the loop that sets it is
// the phase/check-accumulator update (eight unrolled CRC steps per byte).
// Reset clears both stages, the block state and the registers; the parser
// then waits for a node address byte. When the receiver holds out_ready low
// the result register keeps its item, the held byte waits in the input
// register and in_ready drops, even for a byte that would yield no result.
// Registers (APB, 4-byte spacing): expected_nad, crc_mode, ignore_edc_error.
// Write them only while the block is idle.
// ----------------------------------------------------------------------------
module t1_block_deframer
	import t1bd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [AddrWidth-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	// received bytes
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           rx_byte,
	input  logic                 frame_end,
	// results
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 kind,
	output logic [7:0]           info_byte,
	output logic [7:0]           control_byte,
	output logic [7:0]           info_length,
	output logic [1:0]           status
);

	cfg_t     cfg;
	rx_item_t in_item;
	rx_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     out_free;
	logic     emit;
	result_t  result;
	result_t  result_q;

	assign in_item.rx_byte   = rx_byte;
	assign in_item.frame_end = frame_end;

	// held byte moves on when the result slot is free
	assign advance = valid_s1 && out_free;

	t1bd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	t1bd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	t1bd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item_s1 (item_s1),
		.emit    (emit),
		.result  (result)
	);

	t1bd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result    (result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign kind         = result_q.kind;
	assign info_byte    = result_q.info_byte;
	assign control_byte = result_q.control_byte;
	assign info_length  = result_q.info_length;
	assign status       = result_q.status;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the T=1 block deframer. A walked table of directed
// bytes runs on reset settings; randomized traffic follows under six register
// settings. Most blocks are well formed; the rest carry a wrong address, a
// bad length, a short frame, a corrupted check byte, trailing bytes or noise.
// Every accepted byte is run through a local parser model. Every result item
// is compared field by field against the queue of predicted items.
// ----------------------------------------------------------------------------
module tb;
	import t1bd_pkg::*;

	localparam int CycleLimit   = 200000;
	localparam int PressureHold = 400;

	// byte as offered, with an optional typed-in expectation
	typedef struct packed {
		rx_item_t item;
		logic     pinned;
		result_t  pinned_res;
	} rx_entry_t;

	typedef enum int {FAULT_NONE, FAULT_NAD, FAULT_LEN, FAULT_SHORT, FAULT_EDC, FAULT_TRAIL} fault_t;

	localparam result_t NoRes = '0;

	// directed bytes on reset settings: address 00, lrc, strict checking
	localparam rx_entry_t DirTable [26] = '{
		// wrong address on a one-byte frame
		{8'hFF, 1'b1, 1'b1, KindStatus, 8'h00, 8'h00, 8'h00, StNad},
		// wrong address, rest of frame skipped
		{8'h5A, 1'b0, 1'b1, KindStatus, 8'h00, 8'h00, 8'h00, StNad},
		{8'h00, 1'b1, 1'b0, NoRes},
		// length 255 rejected at once
		{8'h00, 1'b0, 1'b0, NoRes},
		{8'hA5, 1'b0, 1'b0, NoRes},
		{8'hFF, 1'b1, 1'b1, KindStatus, 8'h00, 8'hA5, 8'hFF, StLen},
		// empty block, then a trailing byte dropped
		{8'h00, 1'b0, 1'b0, NoRes},
		{8'h00, 1'b0, 1'b0, NoRes},
		{8'h00, 1'b0, 1'b0, NoRes},
		{8'h00, 1'b0, 1'b1, KindStatus, 8'h00, 8'h00, 8'h00, StOk},
		{8'hEE, 1'b1, 1'b0, NoRes},
		// two information bytes, good lrc
		{8'h00, 1'b0, 1'b0, NoRes},
		{8'h40, 1'b0, 1'b0, NoRes},
		{8'h02, 1'b0, 1'b0, NoRes},
		{8'hFF, 1'b0, 1'b1, KindInfo, 8'hFF, 8'h40, 8'h02, StOk},
		{8'h80, 1'b0, 1'b1, KindInfo, 8'h80, 8'h40, 8'h02, StOk},
		{8'h3D, 1'b1, 1'b1, KindStatus, 8'h00, 8'h40, 8'h02, StOk},
		// lrc mismatch
		{8'h00, 1'b0, 1'b0, NoRes},
		{8'h12, 1'b0, 1'b0, NoRes},
		{8'h01, 1'b0, 1'b0, NoRes},
		{8'hAA, 1'b0, 1'b1, KindInfo, 8'hAA, 8'h12, 8'h01, StOk},
		{8'h00, 1'b1, 1'b1, KindStatus, 8'h00, 8'h12, 8'h01, StEdc},
		// frame ends on an information byte
		{8'h00, 1'b0, 1'b0, NoRes},
		{8'h7F, 1'b0, 1'b0, NoRes},
		{8'h03, 1'b0, 1'b0, NoRes},
		{8'h55, 1'b1, 1'b1, KindStatus, 8'h00, 8'h7F, 8'h03, StLen}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [AddrWidth-1:0] paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = 8'h00;
	logic                 frame_end = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 kind;
	logic [7:0]           info_byte;
	logic [7:0]           control_byte;
	logic [7:0]           info_length;
	logic [1:0]           status;

	// live register copy and parser state of the model
	cfg_t        tb_cfg = '0;
	phase_t      rx_phase = PH_NAD;
	logic [15:0] edc_acc = '0;
	logic [7:0]  pcb_hold = '0;
	logic [7:0]  len_hold = '0;
	logic [7:0]  inf_left = '0;

	rx_entry_t rx_queue [$];
	result_t   due_results [$];
	rx_entry_t cur_rx = '0;

	int  rx_pushed = 0;
	int  rx_accepted = 0;
	int  rx_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	int  hold_asks = 0;
	int  hold_done = 0;
	bit  idle_on = 1'b1;
	int  failures = 0;
	int  cycle_count = 0;
	int  blocks_queued = 0;
	int  info_seen = 0;
	int  status_seen [4] = '{0, 0, 0, 0};

	t1_block_deframer u_dut (.*);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// running lrc or crc over one byte, crc msb first
	function automatic logic [15:0] edc_next(input logic mode, input logic [15:0] acc,
			input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		if (!mode) begin
			return {8'h00, acc[7:0] ^ b};
		end
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = r[15] ^ b[k];
			r = (r ^ (fb ? CrcPoly : 16'h0000)) << 1;
		end
		return r;
	endfunction

	// status item ends the block
	function automatic void close_block(input logic [1:0] st, input logic last);
		due_results.push_back({KindStatus, 8'h00, pcb_hold, len_hold, st});
		rx_phase = last ? PH_NAD : PH_SKIP;
	endfunction

	// parser model: one received byte in, expected items queued
	function automatic void deframe_byte(input logic [7:0] b, input logic last);
		logic bad;
		case (rx_phase)
			PH_NAD: begin
				pcb_hold = 8'h00;
				len_hold = 8'h00;
				inf_left = 8'h00;
				if (b != tb_cfg.expected_nad) begin
					close_block(StNad, last);
				end else begin
					edc_acc = edc_next(tb_cfg.crc_mode, tb_cfg.crc_mode ? CrcInit : 16'h0000, b);
					if (last) close_block(StLen, 1'b1);
					else rx_phase = PH_PCB;
				end
			end
			PH_PCB: begin
				pcb_hold = b;
				edc_acc = edc_next(tb_cfg.crc_mode, edc_acc, b);
				if (last) close_block(StLen, 1'b1);
				else rx_phase = PH_LEN;
			end
			PH_LEN: begin
				len_hold = b;
				if (b == LenBad || last) begin
					close_block(StLen, last);
				end else begin
					edc_acc = edc_next(tb_cfg.crc_mode, edc_acc, b);
					inf_left = b;
					rx_phase = (b == 8'd0) ? PH_EDC0 : PH_INF;
				end
			end
			PH_INF: begin
				if (last) begin
					close_block(StLen, 1'b1);
				end else begin
					edc_acc = edc_next(tb_cfg.crc_mode, edc_acc, b);
					inf_left = inf_left - 8'd1;
					if (inf_left == 8'd0) rx_phase = PH_EDC0;
					due_results.push_back({KindInfo, b, pcb_hold, len_hold, StOk});
				end
			end
			PH_EDC0: begin
				bad = (b != edc_acc[7:0]) && !tb_cfg.ignore_edc_error;
				if (!tb_cfg.crc_mode) begin
					close_block(bad ? StEdc : StOk, last);
				end else if (last) begin
					close_block(StLen, 1'b1);
				end else begin
					// low byte mismatch is reported on the high byte
					inf_left = {7'd0, bad};
					rx_phase = PH_EDC1;
				end
			end
			PH_EDC1: begin
				bad = (inf_left != 8'd0) ||
					((b != edc_acc[15:8]) && !tb_cfg.ignore_edc_error);
				inf_left = 8'h00;
				close_block(bad ? StEdc : StOk, last);
			end
			default: begin
				if (last) rx_phase = PH_NAD;
			end
		endcase
	endfunction

	function automatic void push_rx(input rx_entry_t e);
		rx_queue.push_back(e);
		rx_pushed++;
	endfunction

	// one block with correct check bytes, then the requested damage
	function automatic void queue_block(input fault_t fault, input int fixed_len);
		logic [7:0]  blk [$];
		logic [15:0] acc;
		logic [7:0]  len;
		int          n_inf;
		int          pos;
		if (fixed_len >= 0) len = 8'(fixed_len);
		else if (fault == FAULT_LEN) len = LenBad;
		else if ($urandom_range(0, 39) == 0) len = 8'($urandom_range(100, 254));
		else len = 8'($urandom_range(0, 10));
		blk.push_back((fault == FAULT_NAD) ?
			tb_cfg.expected_nad ^ 8'($urandom_range(1, 255)) : tb_cfg.expected_nad);
		blk.push_back(8'($urandom));
		blk.push_back(len);
		n_inf = (len == LenBad) ? $urandom_range(0, 3) : int'(len);
		repeat (n_inf) blk.push_back(8'($urandom));
		acc = tb_cfg.crc_mode ? CrcInit : 16'h0000;
		foreach (blk[i]) acc = edc_next(tb_cfg.crc_mode, acc, blk[i]);
		blk.push_back(acc[7:0]);
		if (tb_cfg.crc_mode) blk.push_back(acc[15:8]);
		case (fault)
			FAULT_EDC: begin
				pos = $urandom_range(3 + n_inf, blk.size() - 1);
				blk[pos] = blk[pos] ^ 8'($urandom_range(1, 255));
			end
			FAULT_SHORT: begin
				pos = $urandom_range(1, blk.size() - 1);
				while (blk.size() > pos) void'(blk.pop_back());
			end
			FAULT_TRAIL: begin
				repeat ($urandom_range(1, 5)) blk.push_back(8'($urandom));
			end
			default: ;
		endcase
		foreach (blk[i]) push_rx({blk[i], i == blk.size() - 1, 1'b0, NoRes});
		blocks_queued++;
	endfunction

	// random mix, mostly well-formed blocks; every sequence closes its frame
	task automatic queue_traffic(input int count);
		int start;
		int pick;
		int n;
		start = rx_pushed;
		while (rx_pushed - start < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) queue_block(FAULT_NONE, -1);
			else if (pick < 68) queue_block(FAULT_NAD, -1);
			else if (pick < 73) queue_block(FAULT_LEN, -1);
			else if (pick < 82) queue_block(FAULT_SHORT, -1);
			else if (pick < 92) queue_block(FAULT_EDC, -1);
			else if (pick < 97) queue_block(FAULT_TRAIL, -1);
			else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					push_rx({8'($urandom), (i == n - 1) || ($urandom_range(0, 1) == 1),
						1'b0, NoRes});
				end
			end
		end
	endtask

	// apb write: setup, then access
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AddrWidth'({idx, 2'b00});
		pwdata <= {24'h000000, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegNad:     tb_cfg.expected_nad = value;
			RegCrcMode: tb_cfg.crc_mode = value[0];
			RegIgnore:  tb_cfg.ignore_edc_error = value[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [7:0] nad, input logic mode, input logic ign);
		write_reg(RegNad, nad);
		write_reg(RegCrcMode, {7'd0, mode});
		write_reg(RegIgnore, {7'd0, ign});
	endtask

	// all bytes taken and all items back, then let the pipeline empty
	task automatic wait_drained();
		do @(posedge clk);
		while (rx_accepted != rx_pushed || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic void check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", field, want, got);
			failures++;
		end
	endfunction

	// byte sender with idle bursts
	always @(posedge clk) begin
		int due_before;
		if (arst_n) begin
			// predict the item taken at this edge
			if (in_valid && in_ready) begin
				due_before = due_results.size();
				deframe_byte(cur_rx.item.rx_byte, cur_rx.item.frame_end);
				if (cur_rx.pinned) begin
					while (due_results.size() > due_before) void'(due_results.pop_back());
					due_results.push_back(cur_rx.pinned_res);
				end
				rx_accepted++;
			end
			// offer the next item or sit out a gap
			if (!in_valid || in_ready) begin
				if (idle_on && rx_gap > 0) begin
					rx_gap--;
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 9) == 0) begin
					rx_gap = $urandom_range(0, 16);
					in_valid <= 1'b0;
				end else if (rx_queue.size() != 0) begin
					cur_rx = rx_queue.pop_front();
					in_valid <= 1'b1;
					rx_byte <= cur_rx.item.rx_byte;
					frame_end <= cur_rx.item.frame_end;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: checks, stall bursts, long hold-off on request
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("unexpected item: kind %0d info %0h status %0d", kind, info_byte, status);
					failures++;
				end else begin
					want = due_results.pop_front();
					check_field("kind", {7'd0, want.kind}, {7'd0, kind});
					check_field("info_byte", want.info_byte, info_byte);
					check_field("control_byte", want.control_byte, control_byte);
					check_field("info_length", want.info_length, info_length);
					check_field("status", {6'd0, want.status}, {6'd0, status});
				end
				if (kind == KindInfo) info_seen++;
				else status_seen[status]++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_asks != hold_done) begin
				hold_done = hold_asks;
				hold_left = PressureHold - 1;
				out_ready <= 1'b0;
			end else if (idle_on && stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				stall_left = $urandom_range(0, 16);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed table on reset settings
		foreach (DirTable[i]) push_rx(DirTable[i]);
		wait_drained();

		// crc, strict checking, one longest block
		set_config(8'h3C, 1'b1, 1'b0);
		queue_block(FAULT_NONE, 254);
		queue_traffic(100);
		wait_drained();

		// lrc, mismatches accepted, top address
		set_config(8'hFF, 1'b0, 1'b1);
		queue_block(FAULT_NONE, 254);
		queue_traffic(50);
		wait_drained();

		// crc, mismatches accepted, zero address
		set_config(8'h00, 1'b1, 1'b1);
		queue_traffic(100);
		wait_drained();

		// receiver holds off while bytes keep coming
		set_config(8'($urandom), 1'b1, 1'b0);
		queue_traffic(100);
		hold_asks++;
		wait_drained();

		set_config(8'($urandom), 1'b0, 1'b0);
		queue_traffic(100);
		wait_drained();

		// closing stretch at full rate
		idle_on = 1'b0;
		set_config(8'($urandom), 1'($urandom), 1'b0);
		queue_traffic(100);
		wait_drained();
		repeat (8) @(posedge clk);

		$display("covered %0d bytes in %0d random blocks over six register settings",
			rx_accepted, blocks_queued);
		$display("items out: %0d info bytes; status ok %0d, address %0d, length %0d, check %0d",
			info_seen, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ----- t1_block_deframer.f -----
src/t1bd_pkg.sv
src/t1bd_cfg_regs.sv
src/t1bd_in_stage.sv
src/t1bd_parser.sv
src/t1bd_out_stage.sv
src/t1_block_deframer.sv
tb/tb.sv
